### design/rlfp_pkg.sv
// ----------------------------------------------------------------------------
// RC link frame parser package
// Constants, register codes and state types shared by the byte intake and the
// channel unpacker, and the CRC-8 step used by the byte intake.
// ----------------------------------------------------------------------------
package rlfp_pkg;

	localparam int MAX_FRAME_BYTES = 64;
	localparam int NUM_CHANNELS    = 16;
	localparam int CHANNEL_BITS    = 11;

	localparam int BYTE_W    = 8;
	localparam int VAL_W     = 11;
	localparam int IDX_W     = 4;
	localparam int COUNT_W   = 32;
	localparam int CFG_IDX_W = 8;

	localparam int ADDR_W = $clog2(MAX_FRAME_BYTES);
	localparam int POS_W  = $clog2(MAX_FRAME_BYTES + 1);
	localparam int LEN_W  = $clog2(MAX_FRAME_BYTES - 1);

	localparam int PAYLOAD_BYTES  = (NUM_CHANNELS * CHANNEL_BITS + 7) / 8;
	localparam int CHAN_FRAME_LEN = PAYLOAD_BYTES + 2;

	// Bit buffer of the unpacker: a partial channel plus one fresh byte.
	localparam int BUF_W = (CHANNEL_BITS + BYTE_W > VAL_W) ? CHANNEL_BITS + BYTE_W : VAL_W;
	localparam int CNT_W = $clog2(BUF_W + 1);
	localparam int CHC_W = $clog2(NUM_CHANNELS + 1);

	localparam logic [BUF_W-1:0] CHAN_MASK = (BUF_W'(1) << CHANNEL_BITS) - BUF_W'(1);

	localparam logic [BYTE_W-1:0] CRC_POLY    = 8'hD5;
	localparam logic [BYTE_W-1:0] LEN_MIN     = 8'd2;
	localparam logic [BYTE_W-1:0] LEN_MAX     = BYTE_W'(MAX_FRAME_BYTES - 2);
	localparam logic [BYTE_W-1:0] SYNC_RESET  = 8'd200;
	localparam logic [BYTE_W-1:0] FTYPE_RESET = 8'd22;

	// Fixed places in the frame store.
	localparam logic [ADDR_W-1:0] ADDR_SYNC    = ADDR_W'(0);
	localparam logic [ADDR_W-1:0] ADDR_LEN     = ADDR_W'(1);
	localparam logic [POS_W-1:0]  POS_TYPE     = POS_W'(2);
	localparam logic [ADDR_W-1:0] ADDR_PAYLOAD = ADDR_W'(3);

	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_BYTE  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TYPE = CFG_IDX_W'(1);

	localparam logic KIND_CHANNEL = 1'b0;
	localparam logic KIND_ERROR   = 1'b1;

	typedef enum logic [1:0] {
		PH_SYNC,
		PH_LEN,
		PH_DATA
	} phase_t;

	typedef enum logic [1:0] {
		UP_IDLE,
		UP_FETCH,
		UP_WAIT,
		UP_EXTRACT
	} up_state_t;

	typedef struct packed {
		logic                    en;
		logic [ADDR_W-1:0]       addr;
		logic [BYTE_W-1:0]       data;
	} rlfp_wr_t;

	typedef struct packed {
		logic                    good;
		logic                    bad;
		logic [COUNT_W-1:0]      good_frames;
		logic [COUNT_W-1:0]      bad_checksums;
	} rlfp_evt_t;

	// One byte of CRC-8, MSB first.
	function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
		input logic [BYTE_W-1:0] data);
		logic [BYTE_W-1:0] c;
		c = crc ^ data;
		for (int b = 0; b < BYTE_W; b++) begin
			if (c[BYTE_W-1]) begin
				c = (c << 1) ^ CRC_POLY;
			end else begin
				c = c << 1;
			end
		end
		return c;
	endfunction

endpackage

### design/rlfp_byte_if.sv
// ----------------------------------------------------------------------------
// Received byte channel
// Valid/ready channel that carries one link byte per word.
// ----------------------------------------------------------------------------
interface rlfp_byte_if import rlfp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] byte_in;

	modport source (output valid, output byte_in, input ready);
	modport sink (input valid, input byte_in, output ready);
endinterface

### design/rlfp_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one channel value or checksum error word.
// ----------------------------------------------------------------------------
interface rlfp_result_if import rlfp_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               kind;
	logic [IDX_W-1:0]   channel_index;
	logic [VAL_W-1:0]   channel_value;
	logic               last;
	logic [COUNT_W-1:0] good_frames;
	logic [COUNT_W-1:0] bad_checksums;

	modport source (output valid, output kind, output channel_index, output channel_value,
		output last, output good_frames, output bad_checksums, input ready);
	modport sink (input valid, input kind, input channel_index, input channel_value,
		input last, input good_frames, input bad_checksums, output ready);
endinterface

### design/rlfp_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel that carries a register index and write data.
// ----------------------------------------------------------------------------
interface rlfp_cfg_if import rlfp_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [BYTE_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### design/rlfp_store.sv
// ----------------------------------------------------------------------------
// Frame store
// Byte memory of one frame, one write port and one registered read port.
// ----------------------------------------------------------------------------
module rlfp_store import rlfp_pkg::*; (
	input  logic              clk,
	input  rlfp_wr_t          wr,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [BYTE_W-1:0] rd_data
);

	logic [BYTE_W-1:0] mem [MAX_FRAME_BYTES];
	logic [BYTE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### design/rlfp_rx.sv
// ----------------------------------------------------------------------------
// Byte intake
// Sync and length tracking, frame store writes, running CRC-8, frame
// verdict and the frame counters. Holds the configuration registers.
// ----------------------------------------------------------------------------
module rlfp_rx import rlfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	rlfp_byte_if.sink   rx,
	rlfp_cfg_if.sink    cfg,
	input  logic        busy,
	output rlfp_wr_t    wr,
	output rlfp_evt_t   evt
);

	phase_t             phase_q, phase_d;
	logic [POS_W-1:0]   pos_q;
	logic [LEN_W-1:0]   len_q;
	logic [BYTE_W-1:0]  crc_q;
	logic [BYTE_W-1:0]  type_q;
	logic [BYTE_W-1:0]  sync_q;
	logic [BYTE_W-1:0]  ftype_q;
	logic [COUNT_W-1:0] good_q;
	logic [COUNT_W-1:0] bad_q;

	logic              acc;
	logic              len_ok;
	logic              is_sync;
	logic              is_final;
	logic              crc_ok;
	logic [BYTE_W-1:0] crc_next;

	assign rx.ready  = !busy;
	assign cfg.ready = 1'b1;

	assign acc      = rx.valid && !busy;
	assign len_ok   = (rx.byte_in >= LEN_MIN) && (rx.byte_in <= LEN_MAX);
	assign is_sync  = (rx.byte_in == sync_q);
	assign is_final = (pos_q == (POS_W'(len_q) + POS_W'(1)));
	assign crc_ok   = (crc_q == rx.byte_in);
	assign crc_next = crc8_byte(crc_q, rx.byte_in);

	always_comb begin
		phase_d = phase_q;
		if (acc) begin
			case (phase_q)
				PH_LEN: begin
					phase_d = len_ok ? PH_DATA : PH_SYNC;
				end
				PH_DATA: begin
					if (is_final) begin
						phase_d = PH_SYNC;
					end
				end
				default: begin
					phase_d = is_sync ? PH_LEN : PH_SYNC;
				end
			endcase
		end
	end

	always_comb begin
		wr.en   = 1'b0;
		wr.addr = ADDR_SYNC;
		wr.data = rx.byte_in;
		evt.good = 1'b0;
		evt.bad  = 1'b0;
		case (phase_q)
			PH_LEN: begin
				wr.en   = acc && len_ok;
				wr.addr = ADDR_LEN;
			end
			PH_DATA: begin
				wr.en   = acc;
				wr.addr = pos_q[ADDR_W-1:0];
				evt.bad  = acc && is_final && !crc_ok;
				evt.good = acc && is_final && crc_ok && (type_q == ftype_q) &&
					(len_q == LEN_W'(CHAN_FRAME_LEN));
			end
			default: begin
				wr.en   = acc && is_sync;
				wr.addr = ADDR_SYNC;
			end
		endcase
		evt.good_frames   = good_q + COUNT_W'(evt.good);
		evt.bad_checksums = bad_q + COUNT_W'(evt.bad);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC;
			pos_q   <= '0;
			len_q   <= '0;
			good_q  <= '0;
			bad_q   <= '0;
			sync_q  <= SYNC_RESET;
			ftype_q <= FTYPE_RESET;
		end else begin
			phase_q <= phase_d;
			good_q  <= evt.good_frames;
			bad_q   <= evt.bad_checksums;
			if (acc) begin
				case (phase_q)
					PH_LEN: begin
						if (len_ok) begin
							len_q <= LEN_W'(rx.byte_in);
							pos_q <= POS_W'(2);
						end
					end
					PH_DATA: begin
						pos_q <= pos_q + POS_W'(1);
					end
					default: begin
						if (is_sync) begin
							pos_q <= POS_W'(1);
						end
					end
				endcase
			end
			if (cfg.valid) begin
				case (cfg.index)
					CFG_SYNC_BYTE:  sync_q  <= cfg.data;
					CFG_FRAME_TYPE: ftype_q <= cfg.data;
					default: ;
				endcase
			end
		end
	end

	// The CRC covers the type and payload, never the trailing check byte.
	always_ff @(posedge clk) begin
		if (acc && phase_q == PH_LEN) begin
			crc_q <= '0;
		end else if (acc && phase_q == PH_DATA && !is_final) begin
			crc_q <= crc_next;
		end
		if (acc && phase_q == PH_DATA && pos_q == POS_TYPE) begin
			type_q <= rx.byte_in;
		end
	end

endmodule

### design/rlfp_unpack.sv
// ----------------------------------------------------------------------------
// Channel unpacker
// Reads the payload of a good channel frame back from the frame store one
// byte at a time, slices it into channel values and drives the result word.
// ----------------------------------------------------------------------------
module rlfp_unpack import rlfp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  rlfp_evt_t         evt,
	output logic              rd_en,
	output logic [ADDR_W-1:0] rd_addr,
	input  logic [BYTE_W-1:0] rd_data,
	output logic              busy,
	rlfp_result_if.source     res
);

	up_state_t          st_q, st_d;
	logic [ADDR_W-1:0]  addr_q;
	logic [BUF_W-1:0]   buf_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CHC_W-1:0]   ch_q;
	logic [COUNT_W-1:0] good_snap_q;
	logic [COUNT_W-1:0] bad_snap_q;

	logic               out_valid_q;
	logic               kind_q;
	logic [IDX_W-1:0]   idx_q;
	logic [VAL_W-1:0]   val_q;
	logic               last_q;
	logic [COUNT_W-1:0] good_out_q;
	logic [COUNT_W-1:0] bad_out_q;

	logic             out_free;
	logic             have_chan;
	logic             load_chan;
	logic             last_chan;
	logic [BUF_W-1:0] chan_bits;

	assign out_free  = !out_valid_q || res.ready;
	assign have_chan = (cnt_q >= CNT_W'(CHANNEL_BITS));
	assign last_chan = (ch_q == CHC_W'(NUM_CHANNELS - 1));
	assign chan_bits = buf_q & CHAN_MASK;
	assign busy      = (st_q != UP_IDLE) || out_valid_q;

	always_comb begin
		st_d = st_q;
		case (st_q)
			UP_IDLE: begin
				if (evt.good) begin
					st_d = UP_FETCH;
				end
			end
			UP_FETCH: begin
				st_d = UP_WAIT;
			end
			UP_WAIT: begin
				st_d = UP_EXTRACT;
			end
			UP_EXTRACT: begin
				if (!have_chan) begin
					st_d = UP_FETCH;
				end else if (out_free && last_chan) begin
					st_d = UP_IDLE;
				end
			end
			default: begin
				st_d = UP_IDLE;
			end
		endcase
	end

	always_comb begin
		rd_en     = 1'b0;
		load_chan = 1'b0;
		case (st_q)
			UP_FETCH:   rd_en = 1'b1;
			UP_EXTRACT: load_chan = have_chan && out_free;
			default: ;
		endcase
	end

	assign rd_addr = addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= UP_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (load_chan || evt.bad) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			UP_IDLE: begin
				addr_q      <= ADDR_PAYLOAD;
				buf_q       <= '0;
				cnt_q       <= '0;
				ch_q        <= '0;
				good_snap_q <= evt.good_frames;
				bad_snap_q  <= evt.bad_checksums;
			end
			UP_FETCH: begin
				addr_q <= addr_q + ADDR_W'(1);
			end
			UP_WAIT: begin
				// The fresh byte lands above the bits still waiting.
				buf_q <= buf_q | (BUF_W'(rd_data) << cnt_q);
				cnt_q <= cnt_q + CNT_W'(BYTE_W);
			end
			UP_EXTRACT: begin
				if (load_chan) begin
					buf_q <= buf_q >> CHANNEL_BITS;
					cnt_q <= cnt_q - CNT_W'(CHANNEL_BITS);
					ch_q  <= ch_q + CHC_W'(1);
				end
			end
			default: ;
		endcase

		if (evt.bad) begin
			kind_q     <= KIND_ERROR;
			idx_q      <= '0;
			val_q      <= '0;
			last_q     <= 1'b1;
			good_out_q <= evt.good_frames;
			bad_out_q  <= evt.bad_checksums;
		end else if (load_chan) begin
			kind_q     <= KIND_CHANNEL;
			idx_q      <= IDX_W'(ch_q);
			val_q      <= chan_bits[VAL_W-1:0];
			last_q     <= last_chan;
			good_out_q <= good_snap_q;
			bad_out_q  <= bad_snap_q;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.kind          = kind_q;
	assign res.channel_index = idx_q;
	assign res.channel_value = val_q;
	assign res.last          = last_q;
	assign res.good_frames   = good_out_q;
	assign res.bad_checksums = bad_out_q;

endmodule

### design/rc_link_frame_parser.sv
// The parser takes one received link byte per word and accepts a byte every
// cycle while no result is pending. It hunts for the sync byte, checks the
// length, stores the frame in a 64-byte frame store and runs the CRC-8 as the
// bytes arrive, so the verdict is known on the check byte itself. A checksum
// error gives one error word; the input then waits until that word is taken.
// A good channel frame is read back from the frame store through its single
// read port one payload byte at a time, each byte fetched, waited for and
// then sliced into channel words as they fill; no byte is accepted during
// that readout.
// ----------------------------------------------------------------------------
// RC link frame parser
// Byte-serial frame parser that checks the CRC and unpacks the packed
// RC channel frame into sixteen channel values.
// ----------------------------------------------------------------------------
module rc_link_frame_parser import rlfp_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	rlfp_byte_if.sink     rx,
	rlfp_cfg_if.sink      cfg,
	rlfp_result_if.source res
);

	rlfp_wr_t          wr;
	rlfp_evt_t         evt;
	logic              busy;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [BYTE_W-1:0] rd_data;

	rlfp_rx u_rx (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.cfg    (cfg),
		.busy   (busy),
		.wr     (wr),
		.evt    (evt)
	);

	rlfp_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	rlfp_unpack u_unpack (
		.clk     (clk),
		.arst_n  (arst_n),
		.evt     (evt),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.busy    (busy),
		.res     (res)
	);

endmodule

### tb/rc_link_frame_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC link frame parser testbench
// Feeds link bytes (directed frames, then random frames, broken frames and
// noise) under several sync/type settings. It predicts every channel and
// checksum error word with its own parser model and checks each word taken
// from the result channel in order. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module rc_link_frame_parser_test;
	import rlfp_pkg::*;

	typedef logic [BYTE_W-1:0] octet_q_t[$];

	typedef struct {
		logic               kind;
		logic [IDX_W-1:0]   idx;
		logic [VAL_W-1:0]   value;
		logic               last;
		logic [COUNT_W-1:0] good;
		logic [COUNT_W-1:0] bad;
	} parser_word_t;

	localparam int IDLE_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 100;

	class link_parser_model;
		logic [BYTE_W-1:0]  sync_reg;
		logic [BYTE_W-1:0]  ftype_reg;
		phase_t             phase;
		logic [BYTE_W-1:0]  store[MAX_FRAME_BYTES];
		int unsigned        wpos;
		int unsigned        blen;
		logic [COUNT_W-1:0] good_cnt;
		logic [COUNT_W-1:0] bad_cnt;
		parser_word_t       pending_words[$];
		int                 failures;

		function new();
			sync_reg  = SYNC_RESET;
			ftype_reg = FTYPE_RESET;
			phase     = PH_SYNC;
			wpos      = 0;
			blen      = 0;
			good_cnt  = '0;
			bad_cnt   = '0;
			failures  = 0;
		endfunction

		static function logic [BYTE_W-1:0] crc8(input octet_q_t data);
			logic [BYTE_W-1:0] c;
			c = '0;
			foreach (data[i]) begin
				c ^= data[i];
				for (int b = 0; b < BYTE_W; b++) begin
					c = c[BYTE_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
				end
			end
			return c;
		endfunction

		function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
			if (idx == CFG_SYNC_BYTE) begin
				sync_reg = data;
			end else if (idx == CFG_FRAME_TYPE) begin
				ftype_reg = data;
			end
		endfunction

		// Advances the parser by one accepted byte and queues the words it causes.
		function void take_byte(input logic [BYTE_W-1:0] b);
			octet_q_t                      covered;
			logic [8*PAYLOAD_BYTES-1:0]    packed_bits;
			parser_word_t                  w;
			case (phase)
				PH_LEN: begin
					if (b < LEN_MIN || b > LEN_MAX) begin
						phase = PH_SYNC;
					end else begin
						blen = b;
						store[ADDR_LEN] = b;
						wpos = 2;
						phase = PH_DATA;
					end
				end
				PH_DATA: begin
					if (wpos < MAX_FRAME_BYTES) begin
						store[wpos] = b;
					end
					wpos++;
					if (wpos >= 2 + blen) begin
						phase = PH_SYNC;
						// The CRC covers the type and payload, the byte after them is the check.
						for (int i = 2; i <= blen; i++) begin
							covered.push_back(store[i]);
						end
						if (crc8(covered) != store[1 + blen]) begin
							bad_cnt++;
							w = '{KIND_ERROR, '0, '0, 1'b1, good_cnt, bad_cnt};
							pending_words.push_back(w);
						end else if (store[2] == ftype_reg && blen == CHAN_FRAME_LEN) begin
							good_cnt++;
							for (int i = 0; i < PAYLOAD_BYTES; i++) begin
								packed_bits[8*i +: 8] = store[3 + i];
							end
							for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
								w = '{KIND_CHANNEL, IDX_W'(ch),
									VAL_W'(packed_bits[ch*CHANNEL_BITS +: CHANNEL_BITS]),
									ch == NUM_CHANNELS - 1, good_cnt, bad_cnt};
								pending_words.push_back(w);
							end
						end
					end
				end
				default: begin
					phase = PH_SYNC;
					if (b == sync_reg) begin
						store[ADDR_SYNC] = b;
						wpos = 1;
						phase = PH_LEN;
					end
				end
			endcase
		endfunction

		function void match_word(input parser_word_t got);
			parser_word_t exp;
			if (pending_words.size() == 0) begin
				$error("result word with nothing expected (kind %0d, channel %0d)",
					got.kind, got.idx);
				failures++;
				return;
			end
			exp = pending_words.pop_front();
			if (got.kind !== exp.kind) begin
				$error("kind: expected %0d, actual %0d", exp.kind, got.kind);
				failures++;
			end
			if (got.idx !== exp.idx) begin
				$error("channel_index: expected %0d, actual %0d", exp.idx, got.idx);
				failures++;
			end
			if (got.value !== exp.value) begin
				$error("channel_value: expected %0d, actual %0d", exp.value, got.value);
				failures++;
			end
			if (got.last !== exp.last) begin
				$error("last: expected %0d, actual %0d", exp.last, got.last);
				failures++;
			end
			if (got.good !== exp.good) begin
				$error("good_frames: expected %0d, actual %0d", exp.good, got.good);
				failures++;
			end
			if (got.bad !== exp.bad) begin
				$error("bad_checksums: expected %0d, actual %0d", exp.bad, got.bad);
				failures++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	rlfp_byte_if   rx_if();
	rlfp_cfg_if    cfg_if();
	rlfp_result_if res_if();

	rc_link_frame_parser uut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.cfg    (cfg_if),
		.res    (res_if)
	);

	link_parser_model sb = new();
	int  sent_bytes = 0;
	int  idle_cycles = 0;
	bit  no_gaps = 1'b0;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Handshake monitor and watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			idle_cycles++;
			if (rx_if.valid && rx_if.ready) begin
				sb.take_byte(rx_if.byte_in);
				idle_cycles = 0;
			end
			if (cfg_if.valid && cfg_if.ready) begin
				sb.write_reg(cfg_if.index, cfg_if.data);
				idle_cycles = 0;
			end
			if (res_if.valid && res_if.ready) begin
				sb.match_word('{res_if.kind, res_if.channel_index, res_if.channel_value,
					res_if.last, res_if.good_frames, res_if.bad_checksums});
				idle_cycles = 0;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// Result side: open stretches, short stalls and now and then a long one.
	initial begin
		int mode;
		res_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 9);
			res_if.ready = 1'b1;
			repeat ($urandom_range(1, mode < 3 ? 60 : 6)) @(negedge clk);
			if (mode >= 3) begin
				res_if.ready = 1'b0;
				repeat (mode == 9 ? $urandom_range(15, 40) : $urandom_range(1, 3)) @(negedge clk);
			end
		end
	end

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int gap;
		int r;
		r = $urandom_range(0, 19);
		gap = no_gaps ? 0 : (r < 10 ? 0 : (r < 18 ? $urandom_range(1, 3) : $urandom_range(10, 30)));
		repeat (gap) @(negedge clk);
		rx_if.valid   = 1'b1;
		rx_if.byte_in = b;
		do @(posedge clk); while (!rx_if.ready);
		@(negedge clk);
		rx_if.valid = 1'b0;
		sent_bytes++;
	endtask

	task automatic send_frame(input logic [BYTE_W-1:0] ftype, input int blen,
		input octet_q_t body, input bit corrupt);
		octet_q_t          covered;
		logic [BYTE_W-1:0] check;
		covered = {ftype, body};
		check = link_parser_model::crc8(covered);
		if (corrupt) begin
			check ^= BYTE_W'($urandom_range(1, 255));
		end
		send_byte(sb.sync_reg);
		send_byte(BYTE_W'(blen));
		foreach (covered[i]) begin
			send_byte(covered[i]);
		end
		send_byte(check);
	endtask

	function automatic octet_q_t rand_body(input int n);
		octet_q_t q;
		repeat (n) q.push_back(BYTE_W'($urandom_range(0, 255)));
		return q;
	endfunction

	function automatic octet_q_t fill_body(input int n, input logic [BYTE_W-1:0] v);
		octet_q_t q;
		repeat (n) q.push_back(v);
		return q;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
		cfg_if.valid = 1'b1;
		cfg_if.index = idx;
		cfg_if.data  = data;
		do @(posedge clk); while (!cfg_if.ready);
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	// Waits until every expected word is in, then lets a frame readout drain.
	task automatic settle();
		while (sb.pending_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic random_frames(input int budget);
		int start;
		int r;
		int blen;
		start = sent_bytes;
		while (sent_bytes - start < budget) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 55) begin
				send_frame(sb.ftype_reg, CHAN_FRAME_LEN, rand_body(PAYLOAD_BYTES), 1'b0);
			end else if (r < 65) begin
				send_frame(sb.ftype_reg, CHAN_FRAME_LEN, rand_body(PAYLOAD_BYTES), 1'b1);
			end else if (r < 75) begin
				blen = ($urandom_range(0, 7) == 0) ? $urandom_range(2, LEN_MAX)
					: $urandom_range(2, 10);
				send_frame(BYTE_W'($urandom_range(0, 255)), blen, rand_body(blen - 2),
					$urandom_range(0, 3) == 0);
			end else if (r < 85) begin
				blen = $urandom_range(2, 12);
				send_frame(sb.ftype_reg, blen, rand_body(blen - 2), 1'b0);
			end else if (r < 92) begin
				send_byte(sb.sync_reg);
				send_byte(($urandom_range(0, 3) == 0) ? BYTE_W'($urandom_range(0, 1))
					: BYTE_W'($urandom_range(LEN_MAX + 1, 255)));
			end else begin
				repeat ($urandom_range(1, 3)) send_byte(BYTE_W'($urandom_range(0, 255)));
			end
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		arst_n        = 1'b0;
		rx_if.valid   = 1'b0;
		rx_if.byte_in = '0;
		cfg_if.valid  = 1'b0;
		cfg_if.index  = '0;
		cfg_if.data   = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: zero channel values, a checksum error, rejected lengths,
		// a silent short frame and the largest frame.
		send_frame(sb.ftype_reg, CHAN_FRAME_LEN, fill_body(PAYLOAD_BYTES, 8'h00), 1'b0);
		send_frame(sb.ftype_reg, CHAN_FRAME_LEN, rand_body(PAYLOAD_BYTES), 1'b1);
		send_byte(sb.sync_reg);
		send_byte(BYTE_W'(LEN_MIN - 1));
		// A length byte equal to the sync value is rejected and does not restart a frame.
		send_byte(sb.sync_reg);
		send_byte(sb.sync_reg);
		send_byte(sb.sync_reg);
		send_byte(BYTE_W'(LEN_MAX + 1));
		send_frame(sb.ftype_reg + 8'd1, LEN_MIN, rand_body(0), 1'b0);
		send_frame(BYTE_W'($urandom_range(0, 255)), LEN_MAX, rand_body(LEN_MAX - 2), 1'b0);

		// Zero sync byte and full-scale channel values.
		settle();
		write_reg(CFG_SYNC_BYTE, 8'h00);
		write_reg(CFG_FRAME_TYPE, 8'hFF);
		write_reg(CFG_IDX_W'($urandom_range(2, 255)), BYTE_W'($urandom_range(0, 255)));
		send_byte(8'h00);
		send_byte(8'h00);
		send_frame(8'hFF, CHAN_FRAME_LEN, fill_body(PAYLOAD_BYTES, 8'hFF), 1'b0);

		settle();
		write_reg(CFG_SYNC_BYTE, 8'hFF);
		write_reg(CFG_FRAME_TYPE, 8'h00);
		random_frames(10);

		settle();
		foreach (sb.pending_words[i]) begin
			$error("missing result word: kind %0d, channel %0d",
				sb.pending_words[i].kind, sb.pending_words[i].idx);
		end
		if (sb.failures == 0 && sb.pending_words.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

### sim.f
design/rlfp_pkg.sv
design/rlfp_byte_if.sv
design/rlfp_result_if.sv
design/rlfp_cfg_if.sv
design/rlfp_store.sv
design/rlfp_rx.sv
design/rlfp_unpack.sv
design/rc_link_frame_parser.sv
tb/rc_link_frame_parser_test.sv
